/* rtl/core/tbb_pkg.sv */
// Shared types and constants for the three pass box blur tile.
// Holds the reciprocal table used by the window mean divider.
// No dependencies.
`default_nettype none
package tbb_pkg;
   typedef logic [15:0] sample_type;
   typedef logic [2:0]  radius_type;

   // Window sums of up to fifteen 16-bit samples fit in 20 bits
   localparam int SUM_W   = 20;
   localparam int RECIP_W = 25;
   localparam int FRAC_W  = 24;

   typedef logic [SUM_W-1:0] sum_type;

   // floor(2^24 / (2r+1)) for each radius
   function automatic logic [RECIP_W-1:0] recip(input radius_type r);
      logic [RECIP_W-1:0] m;
      case (r)
         3'd0:    m = 25'd16777216;
         3'd1:    m = 25'd5592405;
         3'd2:    m = 25'd3355443;
         3'd3:    m = 25'd2396745;
         3'd4:    m = 25'd1864135;
         3'd5:    m = 25'd1525201;
         3'd6:    m = 25'd1290555;
         3'd7:    m = 25'd1118481;
         default: m = 25'd16777216;
      endcase
      return m;
   endfunction
endpackage
`default_nettype wire

/* rtl/core/three_pass_box_blur_tile.sv */
// Three pass box blur of one square tile; top level with sequencer and stores.
// Depends on tbb_pkg, tbb_ram and tbb_div_unit.
// Loading makes 4 store writes per transaction, one per sample. The last
// transaction of a tile starts the blur: for each pass and each direction every sample
// is set by one store read per window tap, r the pass radius, and by the shared mean
// unit; the next sample starts only once the mean of the last one is written. The tile
// is then emitted one result at a time, each after its lane reads. The receiver cannot stall: each result
// is on rsp_* for one cycle with rsp_valid. busy stays high until the last result.
`default_nettype none
module three_pass_box_blur_tile #(
   parameter int TILE_SIDE  = 16,
   parameter int PASS_COUNT = 3
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 start,
   output logic                busy,
   input  wire  [15:0]         req_sample_a,
   input  wire  [15:0]         req_sample_b,
   input  wire  [15:0]         req_sample_c,
   input  wire  [15:0]         req_sample_d,
   output logic                rsp_valid,
   output logic [15:0]         rsp_blurred_a,
   output logic [15:0]         rsp_blurred_b,
   output logic [15:0]         rsp_blurred_c,
   output logic [15:0]         rsp_blurred_d,
   output logic                rsp_tile_end,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [1:0]          csr_index,
   input  wire  [2:0]          csr_data
);
   localparam int CELLS = TILE_SIDE * TILE_SIDE;
   localparam int ITEMS = (CELLS + 3) / 4;
   localparam int AW    = $clog2(CELLS);
   localparam int PW    = $clog2(ITEMS * 4);
   localparam int LW    = $clog2(ITEMS);
   localparam int JW    = $clog2(TILE_SIDE);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_WRITE = 3'd1;
   localparam logic [2:0] S_TAP   = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_ERD   = 3'd5;
   localparam logic [2:0] S_ELAST = 3'd6;
   localparam logic [2:0] S_EOUT  = 3'd7;

   localparam logic [1:0] REG_RADIUS_FIRST  = 2'd0;
   localparam logic [1:0] REG_RADIUS_SECOND = 2'd1;
   localparam logic [1:0] REG_RADIUS_THIRD  = 2'd2;

   logic [2:0]            state_ff, state_in;
   logic [LW-1:0]         item_ff, item_in;
   logic [1:0]            lane_ff, lane_in;
   logic [3:0]            k_ff, k_in;
   logic [JW-1:0]         j_ff, j_in, line_ff, line_in;
   logic                  dir_ff, dir_in;
   logic [1:0]            pass_ff, pass_in;
   tbb_pkg::sum_type      acc_ff, acc_in;
   logic                  pend_ff, pend_in;
   logic                  ebin_ff;
   tbb_pkg::sample_type   samp_ff [4];
   tbb_pkg::sample_type   out_ff [4];
   tbb_pkg::radius_type   radius_ff [3];

   tbb_pkg::radius_type   radius;
   logic signed [7:0]     tap_pos;
   logic [JW-1:0]         tap_cl;
   logic [AW-1:0]         tap_addr;
   logic [PW-1:0]         lane_pos;
   logic                  lane_in_tile;
   logic                  last_item;
   logic                  tap_last;
   logic                  line_end, col_end, pass_end;

   logic                  tile_we, scr_we;
   logic [AW-1:0]         tile_waddr, scr_waddr, tile_raddr;
   tbb_pkg::sample_type   tile_wdata, tile_rdata, scr_rdata, src_rdata;

   logic                  div_go, div_done;
   tbb_pkg::sum_type      div_sum;
   tbb_pkg::sample_type   div_mean;

   assign csr_ready = 1'b1;
   assign busy      = (state_ff != S_IDLE);

   // configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff[0] <= 3'd1;
         radius_ff[1] <= 3'd1;
         radius_ff[2] <= 3'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_RADIUS_FIRST:  radius_ff[0] <= csr_data;
            REG_RADIUS_SECOND: radius_ff[1] <= csr_data;
            REG_RADIUS_THIRD:  radius_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign radius = (pass_ff == 2'd0) ? radius_ff[0] :
                   (pass_ff == 2'd1) ? radius_ff[1] : radius_ff[2];

   // window tap position, clamped to the tile edge
   always_comb begin
      tap_pos = $signed({4'b0, j_ff}) + $signed({4'b0, k_ff}) - $signed({5'b0, radius});
      if (tap_pos < 0) begin
         tap_cl = '0;
      end else if (tap_pos > 8'(TILE_SIDE - 1)) begin
         tap_cl = JW'(TILE_SIDE - 1);
      end else begin
         tap_cl = tap_pos[JW-1:0];
      end
      if (!dir_ff) begin
         tap_addr = AW'(int'(line_ff) * TILE_SIDE + int'(tap_cl));
      end else begin
         tap_addr = AW'(int'(tap_cl) * TILE_SIDE + int'(line_ff));
      end
   end

   assign lane_pos     = PW'(int'(item_ff) * 4 + int'(lane_ff));
   assign lane_in_tile = (int'(lane_pos) < CELLS);
   assign last_item    = (item_ff == LW'(ITEMS - 1));
   assign tap_last     = (k_ff == {radius, 1'b0});
   assign col_end      = (j_ff == JW'(TILE_SIDE - 1));
   assign line_end     = (line_ff == JW'(TILE_SIDE - 1));
   assign pass_end     = (pass_ff == 2'(PASS_COUNT - 1));
   assign src_rdata    = dir_ff ? scr_rdata : tile_rdata;

   // store ports
   always_comb begin
      tile_we    = 1'b0;
      tile_waddr = AW'(lane_pos);
      tile_wdata = samp_ff[lane_ff];
      scr_we     = 1'b0;
      scr_waddr  = AW'(int'(line_ff) * TILE_SIDE + int'(j_ff));
      if (state_ff == S_WRITE) begin
         tile_we = lane_in_tile;
      end else if (state_ff == S_DIV && div_done) begin
         tile_we    = dir_ff;
         scr_we     = !dir_ff;
         tile_waddr = AW'(int'(j_ff) * TILE_SIDE + int'(line_ff));
         tile_wdata = div_mean;
      end
      tile_raddr = (state_ff == S_ERD) ? AW'(lane_pos) : tap_addr;
   end

   tbb_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_tile_ram (
      .clock   (clock),
      .wr_en   (tile_we),
      .wr_addr (tile_waddr),
      .wr_data (tile_wdata),
      .rd_addr (tile_raddr),
      .rd_data (tile_rdata)
   );

   tbb_ram #(.WIDTH(16), .DEPTH(1 << AW)) u_scratch_ram (
      .clock   (clock),
      .wr_en   (scr_we),
      .wr_addr (scr_waddr),
      .wr_data (div_mean),
      .rd_addr (tap_addr),
      .rd_data (scr_rdata)
   );

   assign div_go  = (state_ff == S_DRAIN);
   assign div_sum = acc_ff + tbb_pkg::SUM_W'(src_rdata);

   tbb_div_unit u_div (
      .clock  (clock),
      .reset  (reset),
      .go     (div_go),
      .sum    (div_sum),
      .radius (radius),
      .done   (div_done),
      .mean   (div_mean)
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      lane_in  = lane_ff;
      k_in     = k_ff;
      j_in     = j_ff;
      line_in  = line_ff;
      dir_in   = dir_ff;
      pass_in  = pass_ff;
      acc_in   = acc_ff;
      pend_in  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_WRITE;
               lane_in  = '0;
            end
         end
         S_WRITE: begin
            lane_in = lane_ff + 1'b1;
            if (lane_ff == 2'd3) begin
               if (last_item) begin
                  item_in  = '0;
                  state_in = S_TAP;
                  k_in     = '0;
                  j_in     = '0;
                  line_in  = '0;
                  dir_in   = 1'b0;
                  pass_in  = '0;
                  acc_in   = '0;
               end else begin
                  item_in  = item_ff + 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_TAP: begin
            pend_in = 1'b1;
            k_in    = k_ff + 1'b1;
            if (pend_ff) begin
               acc_in = acc_ff + tbb_pkg::SUM_W'(src_rdata);
            end
            if (tap_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_DIV;
         end
         S_DIV: begin
            if (div_done) begin
               state_in = S_TAP;
               k_in     = '0;
               acc_in   = '0;
               j_in     = j_ff + 1'b1;
               if (col_end) begin
                  j_in    = '0;
                  line_in = line_ff + 1'b1;
                  if (line_end) begin
                     line_in = '0;
                     dir_in  = !dir_ff;
                     if (dir_ff) begin
                        pass_in = pass_ff + 1'b1;
                        if (pass_end) begin
                           pass_in  = '0;
                           state_in = S_ERD;
                           lane_in  = '0;
                           item_in  = '0;
                        end
                     end
                  end
               end
            end
         end
         S_ERD: begin
            lane_in = lane_ff + 1'b1;
            if (lane_ff == 2'd3) begin
               state_in = S_ELAST;
            end
         end
         S_ELAST: begin
            state_in = S_EOUT;
         end
         S_EOUT: begin
            lane_in = '0;
            if (last_item) begin
               item_in  = '0;
               state_in = S_IDLE;
            end else begin
               item_in  = item_ff + 1'b1;
               state_in = S_ERD;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         item_ff  <= '0;
         lane_ff  <= '0;
         k_ff     <= '0;
         j_ff     <= '0;
         line_ff  <= '0;
         dir_ff   <= 1'b0;
         pass_ff  <= '0;
         acc_ff   <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         item_ff  <= item_in;
         lane_ff  <= lane_in;
         k_ff     <= k_in;
         j_ff     <= j_in;
         line_ff  <= line_in;
         dir_ff   <= dir_in;
         pass_ff  <= pass_in;
         acc_ff   <= acc_in;
         pend_ff  <= pend_in;
      end
   end

   // hold the transaction's samples and gather emitted lanes
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         samp_ff[0] <= req_sample_a;
         samp_ff[1] <= req_sample_b;
         samp_ff[2] <= req_sample_c;
         samp_ff[3] <= req_sample_d;
      end
      ebin_ff <= lane_in_tile;
      if (state_ff == S_ERD && lane_ff != 2'd0) begin
         out_ff[lane_ff - 1'b1] <= ebin_ff ? tile_rdata : 16'd0;
      end
      if (state_ff == S_ELAST) begin
         out_ff[3] <= ebin_ff ? tile_rdata : 16'd0;
      end
   end

   assign rsp_valid     = (state_ff == S_EOUT);
   assign rsp_tile_end  = (state_ff == S_EOUT) && last_item;
   assign rsp_blurred_a = out_ff[0];
   assign rsp_blurred_b = out_ff[1];
   assign rsp_blurred_c = out_ff[2];
   assign rsp_blurred_d = out_ff[3];

   // mean unit only finishes while the sequencer waits for it
   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIV))
      else $error("mean unit finished outside wait state");

   // last result of a tile returns the block to idle
   a_end_then_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tile_end) |=> !busy)
      else $error("block still busy after last result");

   // window tap counter never passes the window width
   a_tap_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TAP) |-> (k_ff <= {radius, 1'b0}))
      else $error("window tap counter out of range");

   // results only appear after the lane reads that fill the output registers
   a_rsp_after_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(state_ff) == S_ELAST))
      else $error("result without lane reads");
endmodule
`default_nettype wire

/* rtl/core/tbb_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module tbb_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  wire                       clock,
   input  wire                       wr_en,
   input  wire [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire [WIDTH-1:0]           wr_data,
   input  wire [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]          rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* rtl/core/tbb_div_unit.sv */
// Window mean unit: (sum + r) / (2r+1) by reciprocal multiply and one correction.
// Depends on tbb_pkg. Result is valid with done, after the rounding, multiply and quotient stages.
`default_nettype none
module tbb_div_unit (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  go,
   input  wire tbb_pkg::sum_type    sum,
   input  wire tbb_pkg::radius_type radius,
   output logic                 done,
   output tbb_pkg::sample_type  mean
);
   localparam int PROD_W = tbb_pkg::SUM_W + tbb_pkg::RECIP_W;

   logic [2:0]                  v_ff;
   tbb_pkg::sum_type            x1_ff, x2_ff, x3_ff;
   tbb_pkg::radius_type         r1_ff, r2_ff, r3_ff;
   logic [PROD_W-1:0]           prod_ff;
   tbb_pkg::sum_type            q_ff;
   logic [3:0]                  div;
   logic [tbb_pkg::SUM_W+3:0]   qd;
   tbb_pkg::sum_type            rem;
   tbb_pkg::sum_type            q_fix;

   // advance stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= {v_ff[1:0], go};
      end
   end

   // stage 1 add rounding, stage 2 multiply, stage 3 take quotient estimate
   always_ff @(posedge clock) begin
      x1_ff   <= sum + tbb_pkg::SUM_W'(radius);
      r1_ff   <= radius;
      prod_ff <= x1_ff * tbb_pkg::recip(r1_ff);
      x2_ff   <= x1_ff;
      r2_ff   <= r1_ff;
      q_ff    <= prod_ff[tbb_pkg::FRAC_W +: tbb_pkg::SUM_W];
      x3_ff   <= x2_ff;
      r3_ff   <= r2_ff;
   end

   // correct an estimate that is one short
   always_comb begin
      div   = {r3_ff, 1'b1};
      qd    = q_ff * div;
      rem   = x3_ff - qd[tbb_pkg::SUM_W-1:0];
      q_fix = (rem >= tbb_pkg::SUM_W'(div)) ? q_ff + 1'b1 : q_ff;
   end

   assign done = v_ff[2];
   assign mean = q_fix[15:0];
endmodule
`default_nettype wire
